// ===== src/neuron_mac_activation_assert.svh =====
// Assertion macros for the neuron MAC and activation block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef NEURON_MAC_ACTIVATION_ASSERT_SVH
`define NEURON_MAC_ACTIVATION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nma_pkg.sv =====
// Shared constants and types for the neuron MAC and activation block.
// No dependencies.
`default_nettype none

package nma_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int ACC_WIDTH_DEF  = 40;

    // leaky slope 655 / 2^16, about 0.01
    localparam int LEAKY_MULT  = 655;
    localparam int LEAKY_SHIFT = 16;

    localparam int KIND_WIDTH = 2;

    typedef enum logic [KIND_WIDTH-1:0] {
        ACT_RELU    = 2'd0,
        ACT_IDENT   = 2'd1,
        ACT_SIGMOID = 2'd2,
        ACT_LEAKY   = 2'd3
    } t_act_kind;

endpackage

`default_nettype wire

// ===== src/neuron_mac_activation.sv =====
// Neuron: multiply-accumulate of sample/weight requests, activation on the last one.
// Depends on nma_pkg and neuron_mac_activation_assert.svh.
//
//   channel   signals                                   direction
//   input     i_in_valid/o_in_ready, i_sample,          in
//             i_weight, i_last
//   output    o_out_valid/i_out_ready, o_activation     out
//   config    i_cfg_we, i_cfg_data                      in
//
// A request that is not last goes through latch, multiply and saturating accumulate.
// A last request is then activated (leaky ReLU scales a non-positive sum), the one
// shared multiplier being used again for the leaky slope; the result sits in an output
// register while the next request is accepted, and the final load waits only if
// that register is still full. Synchronous active-low reset clears the accumulator.
`default_nettype none

`include "neuron_mac_activation_assert.svh"

module neuron_mac_activation
    import nma_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire signed [DATA_WIDTH-1:0]   i_sample,
    input  wire signed [DATA_WIDTH-1:0]   i_weight,
    input  wire                           i_last,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic signed [DATA_WIDTH-1:0]  o_activation,
    input  wire                           i_cfg_we,
    input  wire        [KIND_WIDTH-1:0]   i_cfg_data
);

    localparam int XW   = ACC_WIDTH - FRAC_BITS;
    localparam int MA   = DATA_WIDTH + 7;
    localparam int MB   = (DATA_WIDTH > 11) ? DATA_WIDTH : 11;
    localparam int PW   = MA + MB;
    localparam int PRW  = 2 * DATA_WIDTH;
    localparam int T1   = (XW > MA) ? XW : MA;
    localparam int T2   = (T1 > FRAC_BITS + 4) ? T1 : FRAC_BITS + 4;
    localparam int CW   = T2 + 2;
    localparam int SUMW = ((ACC_WIDTH > PRW) ? ACC_WIDTH : PRW) + 1;

    localparam int ONE  = 1 << FRAC_BITS;
    localparam int TH5  = 5 * ONE;
    localparam int TH2  = (19 * ONE + 7) / 8;
    localparam int OFF1 = (27 * ONE) >> 5;
    localparam int OFF2 = (5 * ONE) >> 3;
    localparam int OFF3 = ONE >> 1;

    localparam logic signed [CW-1:0] C_ONE  = CW'(ONE);
    localparam logic signed [CW-1:0] C_TH5  = CW'(TH5);
    localparam logic signed [CW-1:0] C_TH2  = CW'(TH2);
    localparam logic signed [CW-1:0] C_OFF1 = CW'(OFF1);
    localparam logic signed [CW-1:0] C_OFF2 = CW'(OFF2);
    localparam logic signed [CW-1:0] C_OFF3 = CW'(OFF3);

    localparam logic signed [CW-1:0] DMAX_C =
        {{(CW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] DMIN_C =
        {{(CW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [CW-1:0] LMIN_C =
        {{(CW-DATA_WIDTH-6){1'b1}}, {(DATA_WIDTH+6){1'b0}}};
    localparam logic signed [PW-1:0] DMAX_P =
        {{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [PW-1:0] DMIN_P =
        {{(PW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [SUMW-1:0] AMAX_S =
        {{(SUMW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUMW-1:0] AMIN_S =
        {{(SUMW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ACC  = 6'b000100,
        S_ACT  = 6'b001000,
        S_LMUL = 6'b010000,
        S_LSH  = 6'b100000
    } t_state;

    localparam t_state S_DONE_UNUSED = S_IDLE;

    t_state                        r_state, n_state;
    t_act_kind                     r_kind, n_kind;
    logic signed [ACC_WIDTH-1:0]   r_acc, n_acc;
    logic                          r_out_valid, n_out_valid;
    logic                          r_res_valid, n_res_valid;

    logic signed [MA-1:0]          r_a;
    logic signed [MB-1:0]          r_b;
    logic                          r_last;
    logic signed [PW-1:0]          r_prod;
    logic signed [DATA_WIDTH-1:0]  r_res;
    logic signed [DATA_WIDTH-1:0]  r_out;

    logic                          in_acc;
    logic                          out_load;
    logic signed [PW-1:0]          mul_p;
    logic signed [SUMW-1:0]        sum;
    logic signed [ACC_WIDTH-1:0]   acc_sat;
    logic signed [ACC_WIDTH-1:0]   acc_shr;
    logic signed [CW-1:0]          x_c;
    logic signed [CW-1:0]          a_abs;
    logic signed [CW-1:0]          sig_y;
    logic signed [CW-1:0]          sig_v;
    logic signed [CW-1:0]          act_val;
    logic signed [CW-1:0]          lk_op;
    logic signed [DATA_WIDTH-1:0]  sat_c;
    logic signed [PW-1:0]          lk_sh;
    logic signed [DATA_WIDTH-1:0]  sat_p;
    logic                          leaky_neg;

    // shared multiplier: sample*weight, then clamped sum*slope
    assign mul_p = r_a * r_b;

    assign sum = SUMW'(r_acc) + SUMW'($signed(r_prod[PRW-1:0]));
    always_comb begin
        if (sum > AMAX_S) begin
            acc_sat = AMAX_S[ACC_WIDTH-1:0];
        end else if (sum < AMIN_S) begin
            acc_sat = AMIN_S[ACC_WIDTH-1:0];
        end else begin
            acc_sat = sum[ACC_WIDTH-1:0];
        end
    end

    assign acc_shr = r_acc >>> FRAC_BITS;
    assign x_c     = CW'($signed(acc_shr[XW-1:0]));
    assign a_abs   = x_c[CW-1] ? -x_c : x_c;

    // piecewise-linear sigmoid
    always_comb begin
        if (a_abs >= C_TH5) begin
            sig_y = C_ONE;
        end else if (a_abs >= C_TH2) begin
            sig_y = (a_abs >>> 5) + C_OFF1;
        end else if (a_abs >= C_ONE) begin
            sig_y = (a_abs >>> 3) + C_OFF2;
        end else begin
            sig_y = (a_abs >>> 2) + C_OFF3;
        end
        sig_v = x_c[CW-1] ? (C_ONE - sig_y) : sig_y;
    end

    always_comb begin
        case (r_kind)
            ACT_RELU:    act_val = (x_c > 0) ? x_c : '0;
            ACT_IDENT:   act_val = x_c;
            ACT_SIGMOID: act_val = sig_v;
            ACT_LEAKY:   act_val = x_c;
            default:     act_val = x_c;
        endcase
    end

    assign leaky_neg = (r_kind == ACT_LEAKY) && !(x_c > 0);
    assign lk_op     = (x_c < LMIN_C) ? LMIN_C : x_c;

    always_comb begin
        if (act_val > DMAX_C) begin
            sat_c = DMAX_C[DATA_WIDTH-1:0];
        end else if (act_val < DMIN_C) begin
            sat_c = DMIN_C[DATA_WIDTH-1:0];
        end else begin
            sat_c = act_val[DATA_WIDTH-1:0];
        end
    end

    assign lk_sh = r_prod >>> LEAKY_SHIFT;
    always_comb begin
        if (lk_sh > DMAX_P) begin
            sat_p = DMAX_P[DATA_WIDTH-1:0];
        end else if (lk_sh < DMIN_P) begin
            sat_p = DMIN_P[DATA_WIDTH-1:0];
        end else begin
            sat_p = lk_sh[DATA_WIDTH-1:0];
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_res_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    // pending result moves to the output register when it is free
    assign out_load   = r_res_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_res_valid = r_res_valid;
        n_kind      = i_cfg_we ? t_act_kind'(i_cfg_data) : r_kind;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc   = acc_sat;
                n_state = r_last ? S_ACT : S_IDLE;
            end
            S_ACT: begin
                n_acc = '0;
                if (leaky_neg) begin
                    n_state = S_LMUL;
                end else begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                end
            end
            S_LMUL: begin
                n_state = S_LSH;
            end
            S_LSH: begin
                n_state     = S_IDLE;
                n_res_valid = 1'b1;
            end
            default: begin
                n_state = S_DONE_UNUSED;
            end
        endcase
        if (out_load) begin
            n_res_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= ACT_RELU;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a    <= MA'(i_sample);
            r_b    <= MB'(i_weight);
            r_last <= i_last;
        end else if (r_state == S_ACT && leaky_neg) begin
            r_a <= lk_op[MA-1:0];
            r_b <= MB'(LEAKY_MULT);
        end
        if (r_state == S_MUL || r_state == S_LMUL) begin
            r_prod <= mul_p;
        end
        if (r_state == S_ACT && !leaky_neg) begin
            r_res <= sat_c;
        end else if (r_state == S_LSH) begin
            r_res <= sat_p;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_activation = r_out;

    `NMA_ASSERT_NEXT(a_accept_to_mul, in_acc, r_state == S_MUL, "accepted request did not start multiply")
    `NMA_ASSERT_NEXT(a_acc_cleared, r_state == S_ACT, r_acc == '0, "accumulator not cleared after result")
    `NMA_ASSERT_NOW(a_leaky_operand, r_state == S_LMUL, r_a[MA-1] || (r_a == '0), "leaky operand positive")
    `NMA_ASSERT_NEXT(a_pending_lands, r_res_valid && !r_out_valid, r_out_valid, "pending result not moved out")

endmodule

`default_nettype wire
